// File: sv/lcvfe_pkg.sv
// Shared types and defaults for the LED cube voxel frame engine.
package lcvfe_pkg;

    localparam int DEF_SIDE_X      = 8;
    localparam int DEF_SIDE_Y      = 8;
    localparam int DEF_SIDE_Z      = 8;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam int COORD_W = 4;
    localparam int SHIFT_W = 5;
    localparam int LINE_W  = 16;

    typedef enum logic [2:0] {
        CMD_SET  = 3'd0,
        CMD_CLR  = 3'd1,
        CMD_READ = 3'd2,
        CMD_MOVE = 3'd3,
        CMD_WIPE = 3'd4,
        CMD_SHOW = 3'd5,
        CMD_SCAN = 3'd6,
        CMD_NONE = 3'd7
    } cmd_t;

    // Decoded command as it waits in the queue
    typedef struct packed {
        cmd_t                       cmd;
        logic                       in_range;
        logic                       descend;
        logic [COORD_W-1:0]         x;
        logic [COORD_W-1:0]         y;
        logic [COORD_W-1:0]         z;
        logic signed [SHIFT_W-1:0]  dx;
        logic signed [SHIFT_W-1:0]  dy;
        logic signed [SHIFT_W-1:0]  dz;
    } op_t;

endpackage

// File: sv/lcvfe_front.sv
// Command decoder: classifies incoming commands and feeds the queue.
module lcvfe_front
    import lcvfe_pkg::*;
#(
    parameter int SIDE_X = DEF_SIDE_X,
    parameter int SIDE_Y = DEF_SIDE_Y,
    parameter int SIDE_Z = DEF_SIDE_Z
)
(
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 command,
    input  logic [COORD_W-1:0]         voxel_x,
    input  logic [COORD_W-1:0]         voxel_y,
    input  logic [COORD_W-1:0]         voxel_z,
    input  logic signed [SHIFT_W-1:0]  shift_x,
    input  logic signed [SHIFT_W-1:0]  shift_y,
    input  logic signed [SHIFT_W-1:0]  shift_z,
    input  logic                       q_full,
    output logic                       push,
    output op_t                        push_op
);

    function automatic logic [SHIFT_W:0] shift_mag(input logic signed [SHIFT_W-1:0] d);
        logic signed [SHIFT_W:0] w;
        w = {d[SHIFT_W-1], d};
        return w[SHIFT_W] ? (SHIFT_W+1)'(-w) : (SHIFT_W+1)'(w);
    endfunction

    logic big_shift;
    logic no_shift;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    assign big_shift = (shift_mag(shift_x) >= (SHIFT_W+1)'(SIDE_X))
                    || (shift_mag(shift_y) >= (SHIFT_W+1)'(SIDE_Y))
                    || (shift_mag(shift_z) >= (SHIFT_W+1)'(SIDE_Z));
    assign no_shift  = (shift_x == '0) && (shift_y == '0) && (shift_z == '0);

    always_comb
    begin
        push_op.x      = voxel_x;
        push_op.y      = voxel_y;
        push_op.z      = voxel_z;
        push_op.dx     = shift_x;
        push_op.dy     = shift_y;
        push_op.dz     = shift_z;
        push_op.in_range = ({1'b0, voxel_x} < (COORD_W+1)'(SIDE_X))
                        && ({1'b0, voxel_y} < (COORD_W+1)'(SIDE_Y))
                        && ({1'b0, voxel_z} < (COORD_W+1)'(SIDE_Z));
        // rows move toward higher addresses: sweep from the top so sources survive
        push_op.descend = (!shift_z[SHIFT_W-1] && (shift_z != '0))
                       || ((shift_z == '0) && !shift_y[SHIFT_W-1] && (shift_y != '0));
        push_op.cmd = cmd_t'(command);
        if (push_op.cmd == CMD_MOVE)
        begin
            // a shift past the edge empties the frame; a null shift changes nothing
            if (big_shift)
            begin
                push_op.cmd = CMD_WIPE;
            end
            else if (no_shift)
            begin
                push_op.cmd = CMD_NONE;
            end
        end
    end

endmodule

// File: sv/lcvfe_fifo.sv
// Short command queue between the decoder and the executor.
module lcvfe_fifo
    import lcvfe_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output op_t  pop_op,
    output logic not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    op_t             entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_op    = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: sv/lcvfe_back.sv
// Command executor: frame and display stores, row sweeps and scan output.
module lcvfe_back
    import lcvfe_pkg::*;
#(
    parameter int SIDE_X = DEF_SIDE_X,
    parameter int SIDE_Y = DEF_SIDE_Y,
    parameter int SIDE_Z = DEF_SIDE_Z
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  op_t               op,
    output logic              op_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              bit_value,
    output logic [LINE_W-1:0] line_word,
    output logic              last
);

    localparam int NR = SIDE_X > 0 ? SIDE_Y * SIDE_Z : 1;
    localparam int AW = $clog2(NR);
    localparam int XW = $clog2(SIDE_X);
    localparam int YW = $clog2(SIDE_Y);
    localparam int ZW = $clog2(SIDE_Z);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(SIDE_Y);
    localparam logic [YW-1:0] Y_MAX      = YW'(SIDE_Y - 1);
    localparam logic [ZW-1:0] Z_MAX      = ZW'(SIDE_Z - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_PROBE,
        ST_MOVE,
        ST_COPY,
        ST_REPLY,
        ST_SCAN_RD,
        ST_SCAN_OUT,
        ST_SELECT
    } state_t;

    function automatic logic [AW-1:0] row_addr(input logic [ZW-1:0] z, input logic [YW-1:0] y);
        return AW'(z) * ROW_STRIDE + AW'(y);
    endfunction

    function automatic logic [SIDE_X-1:0] shift_row(input logic [SIDE_X-1:0] r,
                                                     input logic signed [SHIFT_W-1:0] d);
        logic [SHIFT_W-1:0] m;
        m = d[SHIFT_W-1] ? SHIFT_W'(-d) : SHIFT_W'(d);
        return d[SHIFT_W-1] ? (r >> m) : (r << m);
    endfunction

    // stores and their read registers
    logic [SIDE_X-1:0] frame_mem [NR];
    logic [SIDE_X-1:0] disp_mem  [NR];
    logic              frame_vld_reg [NR];
    logic              disp_vld_reg  [NR];
    logic [SIDE_X-1:0] frame_rdata_reg;
    logic [SIDE_X-1:0] disp_rdata_reg;
    logic              frame_rvld_reg;
    logic              disp_rvld_reg;
    logic [SIDE_X-1:0] frame_rd;
    logic [SIDE_X-1:0] disp_rd;

    logic              frame_re, frame_we, frame_wipe;
    logic [AW-1:0]     frame_raddr, frame_waddr;
    logic [SIDE_X-1:0] frame_wdata;
    logic              disp_re, disp_we;
    logic [AW-1:0]     disp_raddr, disp_waddr;
    logic [SIDE_X-1:0] disp_wdata;

    // control
    state_t            state_reg, state_next;
    logic [YW-1:0]     y_reg, y_next;
    logic [ZW-1:0]     z_reg, z_next;
    logic [ZW-1:0]     plane_reg, plane_next;
    logic              res_bit_reg, res_bit_next;
    logic              pend_mv_reg, pend_mv_next;
    logic              pend_cp_reg, pend_cp_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    op_t               op_reg;
    logic              pend_ok_reg, pend_ok_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic              out_load;
    logic              bit_value_reg, bit_value_next;
    logic [LINE_W-1:0] line_word_reg, line_word_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic signed [5:0] src_y, src_z;
    logic              src_ok;
    logic [AW-1:0]     sweep_addr;
    logic              sweep_end_up, sweep_end_down;
    logic [SIDE_X-1:0] row_mod;

    assign frame_rd = frame_rvld_reg ? frame_rdata_reg : '0;
    assign disp_rd  = disp_rvld_reg  ? disp_rdata_reg  : '0;
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign bit_value = bit_value_reg;
    assign line_word = line_word_reg;
    assign last      = last_reg;

    // source row of the destination under the current translation
    assign src_y  = $signed({{(6-YW){1'b0}}, y_reg})
                  - $signed({op_reg.dy[SHIFT_W-1], op_reg.dy});
    assign src_z  = $signed({{(6-ZW){1'b0}}, z_reg})
                  - $signed({op_reg.dz[SHIFT_W-1], op_reg.dz});
    assign src_ok = !src_y[5] && (src_y[4:0] < 5'(SIDE_Y))
                 && !src_z[5] && (src_z[4:0] < 5'(SIDE_Z));

    assign sweep_addr     = row_addr(z_reg, y_reg);
    assign sweep_end_up   = (y_reg == Y_MAX) && (z_reg == Z_MAX);
    assign sweep_end_down = (y_reg == '0) && (z_reg == '0);

    always_comb
    begin
        row_mod = frame_rd;
        row_mod[op_reg.x[XW-1:0]] = (op_reg.cmd == CMD_SET);
    end

    always_comb
    begin
        state_next     = state_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        plane_next     = plane_reg;
        res_bit_next   = res_bit_reg;
        pend_mv_next   = 1'b0;
        pend_cp_next   = 1'b0;
        pend_ok_next   = pend_ok_reg;
        pend_addr_next = pend_addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        bit_value_next = 1'b0;
        line_word_next = '0;
        last_next      = 1'b1;
        op_pop         = 1'b0;
        frame_re       = 1'b0;
        frame_raddr    = sweep_addr;
        frame_we       = 1'b0;
        frame_waddr    = pend_addr_reg;
        frame_wdata    = '0;
        frame_wipe     = 1'b0;
        disp_re        = 1'b0;
        disp_raddr     = row_addr(plane_reg, y_reg);
        disp_we        = 1'b0;
        disp_waddr     = pend_addr_reg;
        disp_wdata     = frame_rd;

        // write back the row read by the previous sweep step
        if (pend_mv_reg)
        begin
            frame_we    = 1'b1;
            frame_wdata = pend_ok_reg ? shift_row(frame_rd, op_reg.dx) : '0;
        end
        if (pend_cp_reg)
        begin
            disp_we = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    op_pop       = 1'b1;
                    res_bit_next = 1'b0;
                    state_next   = ST_REPLY;
                    case (op.cmd)
                        CMD_SET, CMD_CLR:
                        begin
                            if (op.in_range)
                            begin
                                frame_re    = 1'b1;
                                frame_raddr = row_addr(op.z[ZW-1:0], op.y[YW-1:0]);
                                state_next  = ST_MODIFY;
                            end
                        end
                        CMD_READ:
                        begin
                            if (op.in_range)
                            begin
                                frame_re    = 1'b1;
                                frame_raddr = row_addr(op.z[ZW-1:0], op.y[YW-1:0]);
                                state_next  = ST_PROBE;
                            end
                        end
                        CMD_MOVE:
                        begin
                            y_next     = op.descend ? Y_MAX : '0;
                            z_next     = op.descend ? Z_MAX : '0;
                            state_next = ST_MOVE;
                        end
                        CMD_WIPE:
                        begin
                            frame_wipe = 1'b1;
                        end
                        CMD_SHOW:
                        begin
                            y_next     = '0;
                            z_next     = '0;
                            state_next = ST_COPY;
                        end
                        CMD_SCAN:
                        begin
                            y_next     = Y_MAX;
                            state_next = ST_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end

            ST_MODIFY:
            begin
                frame_we    = 1'b1;
                frame_waddr = row_addr(op_reg.z[ZW-1:0], op_reg.y[YW-1:0]);
                frame_wdata = row_mod;
                state_next  = ST_REPLY;
            end

            ST_PROBE:
            begin
                res_bit_next = frame_rd[op_reg.x[XW-1:0]];
                state_next   = ST_REPLY;
            end

            ST_MOVE:
            begin
                frame_re       = src_ok;
                frame_raddr    = row_addr(src_z[ZW-1:0], src_y[YW-1:0]);
                pend_mv_next   = 1'b1;
                pend_ok_next   = src_ok;
                pend_addr_next = sweep_addr;
                if (op_reg.descend)
                begin
                    if (sweep_end_down)
                    begin
                        state_next = ST_REPLY;
                    end
                    else if (y_reg == '0)
                    begin
                        y_next = Y_MAX;
                        z_next = z_reg - 1'b1;
                    end
                    else
                    begin
                        y_next = y_reg - 1'b1;
                    end
                end
                else
                begin
                    if (sweep_end_up)
                    begin
                        state_next = ST_REPLY;
                    end
                    else if (y_reg == Y_MAX)
                    begin
                        y_next = '0;
                        z_next = z_reg + 1'b1;
                    end
                    else
                    begin
                        y_next = y_reg + 1'b1;
                    end
                end
            end

            ST_COPY:
            begin
                frame_re       = 1'b1;
                pend_cp_next   = 1'b1;
                pend_addr_next = sweep_addr;
                if (sweep_end_up)
                begin
                    state_next = ST_REPLY;
                end
                else if (y_reg == Y_MAX)
                begin
                    y_next = '0;
                    z_next = z_reg + 1'b1;
                end
                else
                begin
                    y_next = y_reg + 1'b1;
                end
            end

            ST_REPLY:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    bit_value_next = res_bit_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_SCAN_RD:
            begin
                disp_re    = 1'b1;
                state_next = ST_SCAN_OUT;
            end

            ST_SCAN_OUT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    line_word_next = LINE_W'(disp_rd);
                    last_next      = 1'b0;
                    if (y_reg == '0)
                    begin
                        state_next = ST_SELECT;
                    end
                    else
                    begin
                        y_next     = y_reg - 1'b1;
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            ST_SELECT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    line_word_next = LINE_W'(1) << plane_reg;
                    plane_next     = (plane_reg == Z_MAX) ? '0 : plane_reg + 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            y_reg          <= '0;
            z_reg          <= '0;
            plane_reg      <= '0;
            res_bit_reg    <= 1'b0;
            pend_mv_reg    <= 1'b0;
            pend_cp_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            frame_rvld_reg <= 1'b0;
            disp_rvld_reg  <= 1'b0;
            for (int i = 0; i < NR; i++)
            begin
                frame_vld_reg[i] <= 1'b0;
                disp_vld_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            plane_reg     <= plane_next;
            res_bit_reg   <= res_bit_next;
            pend_mv_reg   <= pend_mv_next;
            pend_cp_reg   <= pend_cp_next;
            out_valid_reg <= out_valid_next;
            if (frame_re)
            begin
                frame_rvld_reg <= frame_vld_reg[frame_raddr];
            end
            if (disp_re)
            begin
                disp_rvld_reg <= disp_vld_reg[disp_raddr];
            end
            // an invalid row reads as zero, so clear-all just drops the marks
            if (frame_wipe)
            begin
                for (int i = 0; i < NR; i++)
                begin
                    frame_vld_reg[i] <= 1'b0;
                end
            end
            else if (frame_we)
            begin
                frame_vld_reg[frame_waddr] <= 1'b1;
            end
            if (disp_we)
            begin
                disp_vld_reg[disp_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            op_reg <= op;
        end
        pend_ok_reg   <= pend_ok_next;
        pend_addr_reg <= pend_addr_next;
        if (out_load)
        begin
            bit_value_reg <= bit_value_next;
            line_word_reg <= line_word_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        if (frame_re)
        begin
            frame_rdata_reg <= frame_mem[frame_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (disp_we)
        begin
            disp_mem[disp_waddr] <= disp_wdata;
        end
        if (disp_re)
        begin
            disp_rdata_reg <= disp_mem[disp_raddr];
        end
    end

endmodule

// File: sv/led_cube_voxel_frame_engine_core.sv
// Top level of the LED cube voxel frame engine.
// Commands enter a small queue (depth Q_DEPTH) and run one at a time in the
// executor, which owns a single-port-read frame store and display store of
// SIDE_Y*SIDE_Z rows of SIDE_X bits. Set and clear read the row, write it back
// and then reply; read fetches the row and then replies; clear-all, no-op and
// out-of-range voxel commands go straight to the reply. Translate and display
// update sweep every row through the frame store read port, one row per cycle.
// Scan sends each row of the current display plane (display store read, then
// output register) plus one plane-select word. Both stores read as zero right
// after reset through per-row valid flags, with no clearing pass. The result
// register lets the queue keep taking commands while a result waits.
module led_cube_voxel_frame_engine_core
    import lcvfe_pkg::*;
#(
    parameter int SIDE_X  = DEF_SIDE_X,
    parameter int SIDE_Y  = DEF_SIDE_Y,
    parameter int SIDE_Z  = DEF_SIDE_Z,
    parameter int Q_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 command,
    input  logic [COORD_W-1:0]         voxel_x,
    input  logic [COORD_W-1:0]         voxel_y,
    input  logic [COORD_W-1:0]         voxel_z,
    input  logic signed [SHIFT_W-1:0]  shift_x,
    input  logic signed [SHIFT_W-1:0]  shift_y,
    input  logic signed [SHIFT_W-1:0]  shift_z,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       bit_value,
    output logic [LINE_W-1:0]          line_word,
    output logic                       last
);

    logic q_full;
    logic push;
    op_t  push_op;
    logic pop;
    op_t  pop_op;
    logic q_valid;

    lcvfe_front #(
        .SIDE_X (SIDE_X),
        .SIDE_Y (SIDE_Y),
        .SIDE_Z (SIDE_Z)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .voxel_x  (voxel_x),
        .voxel_y  (voxel_y),
        .voxel_z  (voxel_z),
        .shift_x  (shift_x),
        .shift_y  (shift_y),
        .shift_z  (shift_z),
        .q_full   (q_full),
        .push     (push),
        .push_op  (push_op)
    );

    lcvfe_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (pop),
        .pop_op    (pop_op),
        .not_empty (q_valid)
    );

    lcvfe_back #(
        .SIDE_X (SIDE_X),
        .SIDE_Y (SIDE_Y),
        .SIDE_Z (SIDE_Z)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_valid),
        .op        (pop_op),
        .op_pop    (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bit_value (bit_value),
        .line_word (line_word),
        .last      (last)
    );

endmodule
